[rtl/core/ess_pkg.sv]
package ess_pkg;

  // Sensor kinds.
  localparam logic [3:0] KIND_RAW      = 4'd0;
  localparam logic [3:0] KIND_AIR      = 4'd1;
  localparam logic [3:0] KIND_COOLANT  = 4'd2;
  localparam logic [3:0] KIND_EGR      = 4'd3;
  localparam logic [3:0] KIND_BATTERY  = 4'd4;
  localparam logic [3:0] KIND_RPM      = 4'd5;
  localparam logic [3:0] KIND_INJECTOR = 4'd6;
  localparam logic [3:0] KIND_BARO     = 4'd7;
  localparam logic [3:0] KIND_AIRFLOW  = 4'd8;
  localparam logic [3:0] KIND_THROTTLE = 4'd9;
  localparam logic [3:0] KIND_FUELTRIM = 4'd10;
  localparam logic [3:0] KIND_OXYGEN   = 4'd11;
  localparam logic [3:0] KIND_TIMING   = 4'd12;

  // Unit modes.
  localparam logic [1:0] UM_METRIC   = 2'd0;
  localparam logic [1:0] UM_IMPERIAL = 2'd1;

  // Unit codes.
  localparam logic [3:0] UNIT_NONE    = 4'd0;
  localparam logic [3:0] UNIT_DEGC    = 4'd1;
  localparam logic [3:0] UNIT_DEGF    = 4'd2;
  localparam logic [3:0] UNIT_VOLT    = 4'd3;
  localparam logic [3:0] UNIT_RPM     = 4'd4;
  localparam logic [3:0] UNIT_MS      = 4'd5;
  localparam logic [3:0] UNIT_BAR     = 4'd6;
  localparam logic [3:0] UNIT_PSI     = 4'd7;
  localparam logic [3:0] UNIT_HZ      = 4'd8;
  localparam logic [3:0] UNIT_PERCENT = 4'd9;
  localparam logic [3:0] UNIT_DEGREE  = 4'd10;

  localparam logic [1:0] DIG_NONE = 2'd0;
  localparam logic [1:0] DIG_ONE  = 2'd1;
  localparam logic [1:0] DIG_TWO  = 2'd2;

  // Temperature offsets: metric ones in whole degrees, imperial ones in 16.16 times 9/5.
  localparam logic [31:0] OFF_AIR_MET  = 32'd60;
  localparam logic [31:0] OFF_COOL_MET = 32'd80;
  localparam logic [31:0] OFF_AIR_IMP  = 32'd7077888;
  localparam logic [31:0] OFF_COOL_IMP = 32'd9437184;
  localparam logic [31:0] FAHR_BIAS    = 32'd2097152;

  typedef enum logic [1:0] {
    OP_LIN,
    OP_TMET,
    OP_TIMP
  } op_e;

  typedef struct packed {
    logic [1:0] digits;
    logic [3:0] unit;
  } fmt_t;

  typedef struct packed {
    op_e               op;
    logic              is_cool;
    logic [7:0]        x;
    logic signed [22:0] coef;
    logic [31:0]       bias;
    logic [7:0]        a;
    logic [6:0]        diff;
    logic [3:0]        k;
    fmt_t              fmt;
  } s1_t;

  typedef struct packed {
    op_e         op;
    logic        is_cool;
    logic [7:0]  a;
    logic [31:0] prod;
    logic [31:0] bias;
    logic [9:0]  kd;
    logic [11:0] na;
    fmt_t        fmt;
  } s2_t;

  typedef struct packed {
    op_e         op;
    logic        is_cool;
    logic [7:0]  a;
    logic [31:0] prod;
    logic [31:0] bias;
    logic [9:0]  kd;
    logic [9:0]  qa;
    logic [2:0]  ra;
    logic [10:0] qk;
    logic [2:0]  rk;
    fmt_t        fmt;
  } s3_t;

  typedef struct packed {
    logic [31:0] v;
    fmt_t        fmt;
  } s4_t;

  function automatic logic [7:0] temp_lut(input logic is_cool, input logic [4:0] idx);
    logic [7:0] r;
    if (is_cool) begin
      case (idx)
        5'd0:  r = 8'd238;
        5'd1:  r = 8'd190;
        5'd2:  r = 8'd160;
        5'd3:  r = 8'd144;
        5'd4:  r = 8'd132;
        5'd5:  r = 8'd123;
        5'd6:  r = 8'd115;
        5'd7:  r = 8'd108;
        5'd8:  r = 8'd101;
        5'd9:  r = 8'd95;
        5'd10: r = 8'd88;
        5'd11: r = 8'd81;
        5'd12: r = 8'd73;
        5'd13: r = 8'd64;
        5'd14: r = 8'd51;
        default: r = 8'd21;
      endcase
    end else begin
      case (idx)
        5'd0:  r = 8'd244;
        5'd1:  r = 8'd176;
        5'd2:  r = 8'd145;
        5'd3:  r = 8'd128;
        5'd4:  r = 8'd116;
        5'd5:  r = 8'd106;
        5'd6:  r = 8'd98;
        5'd7:  r = 8'd90;
        5'd8:  r = 8'd83;
        5'd9:  r = 8'd76;
        5'd10: r = 8'd69;
        5'd11: r = 8'd62;
        5'd12: r = 8'd53;
        5'd13: r = 8'd43;
        5'd14: r = 8'd29;
        default: r = 8'd1;
      endcase
    end
    return r;
  endfunction

  // Exact quotient by five for any 16-bit value, via the reciprocal 52429 / 2^18.
  function automatic logic [15:0] div5(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'd52429;
    return 16'(p[31:18]);
  endfunction

  // floor(65536 * r / 5) for a remainder r of 0 to 4.
  function automatic logic [15:0] frac_hi(input logic [2:0] r);
    logic [15:0] f;
    case (r)
      3'd1:    f = 16'd13107;
      3'd2:    f = 16'd26214;
      3'd3:    f = 16'd39321;
      3'd4:    f = 16'd52428;
      default: f = 16'd0;
    endcase
    return f;
  endfunction

  // floor(4096 * r / 5) for a remainder r of 0 to 4.
  function automatic logic [11:0] frac_lo(input logic [2:0] r);
    logic [11:0] f;
    case (r)
      3'd1:    f = 12'd819;
      3'd2:    f = 12'd1638;
      3'd3:    f = 12'd2457;
      3'd4:    f = 12'd3276;
      default: f = 12'd0;
    endcase
    return f;
  endfunction

endpackage

[rtl/core/ess_decode.sv]
module ess_decode import ess_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  logic [3:0] req_type_i,
  input  logic [7:0] raw_value_i,
  input  logic [1:0] unit_mode_i,
  output logic       valid_o,
  output s1_t        s1_o
);

  logic valid_q;
  s1_t  s1_d, s1_q;
  logic [4:0] idx;
  logic [7:0] b, diff8;

  always_comb begin
    s1_d = '0;
    s1_d.op      = OP_LIN;
    s1_d.x       = raw_value_i;
    s1_d.coef    = 23'sd65536;
    s1_d.bias    = '0;
    s1_d.is_cool = (req_type_i == KIND_COOLANT);
    s1_d.k       = raw_value_i[3:0];
    s1_d.fmt     = '{digits: DIG_NONE, unit: UNIT_NONE};
    idx          = {1'b0, raw_value_i[7:4]};
    s1_d.a       = temp_lut(s1_d.is_cool, idx);
    b            = temp_lut(s1_d.is_cool, idx + 5'd1);
    diff8        = s1_d.a - b;
    s1_d.diff    = diff8[6:0];

    unique case (req_type_i) inside
      KIND_AIR, KIND_COOLANT: begin
        if (unit_mode_i == UM_METRIC) begin
          s1_d.op  = OP_TMET;
          s1_d.fmt = '{digits: DIG_ONE, unit: UNIT_DEGC};
        end else if (unit_mode_i == UM_IMPERIAL) begin
          s1_d.op  = OP_TIMP;
          s1_d.fmt = '{digits: DIG_ONE, unit: UNIT_DEGF};
        end
      end
      KIND_EGR: begin
        if (unit_mode_i == UM_METRIC) begin
          s1_d.coef = -23'sd98304;
          s1_d.bias = 32'd20596508;
          s1_d.fmt  = '{digits: DIG_ONE, unit: UNIT_DEGC};
        end else if (unit_mode_i == UM_IMPERIAL) begin
          s1_d.coef = -23'sd176947;
          s1_d.bias = 32'd39170867;
          s1_d.fmt  = '{digits: DIG_ONE, unit: UNIT_DEGF};
        end
      end
      KIND_BATTERY: begin
        s1_d.coef = 23'sd4804;
        s1_d.fmt  = '{digits: DIG_ONE, unit: UNIT_VOLT};
      end
      KIND_RPM: begin
        s1_d.coef = 23'sd2048000;
        s1_d.fmt  = '{digits: DIG_NONE, unit: UNIT_RPM};
      end
      KIND_INJECTOR: begin
        s1_d.coef = 23'sd16777;
        s1_d.fmt  = '{digits: DIG_TWO, unit: UNIT_MS};
      end
      KIND_BARO: begin
        if (unit_mode_i == UM_METRIC) begin
          s1_d.coef = 23'sd319;
          s1_d.fmt  = '{digits: DIG_TWO, unit: UNIT_BAR};
        end else if (unit_mode_i == UM_IMPERIAL) begin
          s1_d.coef = 23'sd4619;
          s1_d.fmt  = '{digits: DIG_TWO, unit: UNIT_PSI};
        end
      end
      KIND_AIRFLOW: begin
        s1_d.coef = 23'sd412221;
        s1_d.fmt  = '{digits: DIG_ONE, unit: UNIT_HZ};
      end
      KIND_THROTTLE: begin
        s1_d.coef = 23'sd25600;
        s1_d.fmt  = '{digits: DIG_ONE, unit: UNIT_PERCENT};
      end
      KIND_FUELTRIM: begin
        s1_d.coef = 23'sd51200;
        s1_d.fmt  = '{digits: DIG_ONE, unit: UNIT_PERCENT};
      end
      KIND_OXYGEN: begin
        s1_d.coef = 23'sd1280;
        s1_d.fmt  = '{digits: DIG_TWO, unit: UNIT_VOLT};
      end
      KIND_TIMING: begin
        s1_d.bias = 32'hFFF6_0000;
        s1_d.fmt  = '{digits: DIG_NONE, unit: UNIT_DEGREE};
      end
      default: begin
        // Raw decimal is the default: the byte times one in 16.16.
        s1_d.op = OP_LIN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;

endmodule

[rtl/core/ess_mult.sv]
module ess_mult import ess_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  s1_t  s1_i,
  output logic valid_o,
  output s3_t  s3_o
);

  logic        v2_q, v3_q;
  s2_t         s2_d, s2_q;
  s3_t         s3_d, s3_q;
  logic [31:0] prod_s;
  logic [10:0] kd_full;
  logic [13:0] n9k;
  logic [15:0] qa16, qk16, ra16, rk16;

  // First stage: the scale multiply, and the interpolation step product.
  always_comb begin
    prod_s       = 32'(s1_i.coef) * 32'($signed({1'b0, s1_i.x}));
    kd_full      = 11'(s1_i.k) * 11'(s1_i.diff);
    s2_d.op      = s1_i.op;
    s2_d.is_cool = s1_i.is_cool;
    s2_d.a       = s1_i.a;
    s2_d.prod    = prod_s;
    s2_d.bias    = s1_i.bias;
    s2_d.kd      = kd_full[9:0];
    s2_d.na      = ({4'b0, s1_i.a} << 3) + {4'b0, s1_i.a};
    s2_d.fmt     = s1_i.fmt;
  end

  // Second stage: both truncating divisions by five for the Fahrenheit path.
  always_comb begin
    n9k          = ({4'b0, s2_q.kd} << 3) + {4'b0, s2_q.kd};
    qa16         = div5({4'b0, s2_q.na});
    qk16         = div5({2'b0, n9k});
    ra16         = {4'b0, s2_q.na} - 16'(qa16 * 16'd5);
    rk16         = {2'b0, n9k} - 16'(qk16 * 16'd5);
    s3_d.op      = s2_q.op;
    s3_d.is_cool = s2_q.is_cool;
    s3_d.a       = s2_q.a;
    s3_d.prod    = s2_q.prod;
    s3_d.bias    = s2_q.bias;
    s3_d.kd      = s2_q.kd;
    s3_d.qa      = qa16[9:0];
    s3_d.ra      = ra16[2:0];
    s3_d.qk      = qk16[10:0];
    s3_d.rk      = rk16[2:0];
    s3_d.fmt     = s2_q.fmt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= valid_i;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  assign valid_o = v3_q;
  assign s3_o    = s3_q;

endmodule

[rtl/core/ess_compose.sv]
module ess_compose import ess_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  s3_t  s3_i,
  output logic valid_o,
  output s4_t  s4_o
);

  logic        valid_q;
  s4_t         s4_d, s4_q;
  logic [31:0] off_m, off_i, met, imp;

  // All sums are modulo 2^32, which gives the two's complement 16.16 value.
  always_comb begin
    off_m = s3_i.is_cool ? OFF_COOL_MET : OFF_AIR_MET;
    off_i = s3_i.is_cool ? OFF_COOL_IMP : OFF_AIR_IMP;
    met   = (({24'b0, s3_i.a} - off_m) << 16) - ({22'b0, s3_i.kd} << 12);
    imp   = ({6'b0, s3_i.qa, 16'b0} + {16'b0, frac_hi(s3_i.ra)})
          - ({9'b0, s3_i.qk, 12'b0} + {20'b0, frac_lo(s3_i.rk)})
          - off_i + FAHR_BIAS;
    case (s3_i.op)
      OP_TMET: s4_d.v = met;
      OP_TIMP: s4_d.v = imp;
      default: s4_d.v = s3_i.prod + s3_i.bias;
    endcase
    s4_d.fmt = s3_i.fmt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_q <= s4_d;
    end
  end

  assign valid_o = valid_q;
  assign s4_o    = s4_q;

endmodule

[rtl/core/ess_format.sv]
module ess_format import ess_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  s4_t         s4_i,
  output logic        valid_o,
  output logic [13:0] int_part_o,
  output logic [6:0]  frac_part_o,
  output logic [1:0]  frac_digits_o,
  output logic [3:0]  unit_code_o
);

  logic        valid_q;
  logic [13:0] int_d, int_q;
  logic [6:0]  frac_d, frac_q;
  logic [6:0]  scale;
  logic [22:0] fp;
  fmt_t        fmt_q;

  // Bits above the binary point are already the floor, the fraction stays positive.
  always_comb begin
    case (s4_i.fmt.digits)
      DIG_TWO: scale = 7'd100;
      DIG_ONE: scale = 7'd10;
      default: scale = 7'd0;
    endcase
    fp     = {7'b0, s4_i.v[15:0]} * {16'b0, scale};
    frac_d = fp[22:16];
    int_d  = s4_i.v[29:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      int_q  <= int_d;
      frac_q <= frac_d;
      fmt_q  <= s4_i.fmt;
    end
  end

  assign valid_o       = valid_q;
  assign int_part_o    = int_q;
  assign frac_part_o   = frac_q;
  assign frac_digits_o = fmt_q.digits;
  assign unit_code_o   = fmt_q.unit;

endmodule

[rtl/core/engine_sensor_scaler_top.sv]
// Channel   Direction  Handshake                Payload
// in        sink       in_valid_i / in_stall_o  req_type_i, raw_value_i
// out       source     out_valid_o / out_stall_i int_part_o, frac_part_o,
//                                               frac_digits_o, unit_code_o
// cfg       sink       cfg_valid_i / cfg_ready_o unit_mode_i
//
// One item per cycle while not stalled; each result is valid once its input beat has
// passed five register stages: decode with table lookup, scale multiply,
// divide by five, sum, and fraction digits with the output register.
// Reset clears all valid bits and sets unit mode to metric.
// A stall at the output holds every stage at once and stalls the input too.
module engine_sensor_scaler_top import ess_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  req_type_i,
  input  logic [7:0]  raw_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [13:0] int_part_o,
  output logic [6:0]  frac_part_o,
  output logic [1:0]  frac_digits_o,
  output logic [3:0]  unit_code_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  unit_mode_i
);

  logic [1:0]  unit_mode_q;
  logic        en, v1, v3, v4;
  logic        in_beat;
  s1_t         s1;
  s3_t         s3;
  s4_t         s4;
  logic [13:0] int_bits;

  // The pipeline moves whenever the output register is free or being drained.
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign in_beat     = in_valid_i && en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_mode_q <= UM_METRIC;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unit_mode_q <= unit_mode_i;
    end
  end

  ess_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_beat),
    .req_type_i  (req_type_i),
    .raw_value_i (raw_value_i),
    .unit_mode_i (unit_mode_q),
    .valid_o     (v1),
    .s1_o        (s1)
  );

  ess_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1),
    .s1_i    (s1),
    .valid_o (v3),
    .s3_o    (s3)
  );

  ess_compose u_compose (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3),
    .s3_i    (s3),
    .valid_o (v4),
    .s4_o    (s4)
  );

  ess_format u_format (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (v4),
    .s4_i          (s4),
    .valid_o       (out_valid_o),
    .int_part_o    (int_bits),
    .frac_part_o   (frac_part_o),
    .frac_digits_o (frac_digits_o),
    .unit_code_o   (unit_code_o)
  );

  assign int_part_o = $signed(int_bits);

  a_stall_only_on_full_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output register free");

  a_frac_below_hundred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frac_part_o < 7'd100))
    else $error("fraction digits out of range");

  a_no_digits_no_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frac_digits_o == DIG_NONE) |-> (frac_part_o == 7'd0))
    else $error("fraction present with zero digits");

  a_raw_has_no_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && unit_code_o == UNIT_NONE) |-> (frac_digits_o == DIG_NONE))
    else $error("raw result carries fraction digits");

endmodule
